// File: rtl/core/mandelbrot_escape_time_core_macros.svh
// Assertion macros shared by the Mandelbrot escape-time core RTL.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MET_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MET_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MET_ASSERT_IMP(lbl, ante, cons)
`define MET_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/met_pkg.sv
// Shared types, constants and helper functions of the Mandelbrot escape-time core.
`timescale 1ns / 1ps
package met_pkg;

	localparam int DATA_WIDTH   = 32;
	localparam int FRAC_BITS    = DATA_WIDTH - 6;
	localparam int PROD_W       = 2 * DATA_WIDTH;
	localparam int COORD_BITS   = 12;
	localparam int ITER_BITS    = 16;
	localparam int COUNT_BITS   = ITER_BITS + 1;
	localparam int CFG_IDX_BITS = 3;

	// |z|^2 escape bound: 4.0 at the doubled fraction width of a square
	localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

	// Reset values of the configuration registers
	localparam logic [DATA_WIDTH-1:0] RST_X_START =
		DATA_WIDTH'(0) - (DATA_WIDTH'(2) << FRAC_BITS);
	localparam logic [DATA_WIDTH-2:0] RST_X_STEP  = (DATA_WIDTH-1)'(1) << (FRAC_BITS - 8);
	localparam logic [DATA_WIDTH-1:0] RST_Y_TOP   = DATA_WIDTH'(1) << FRAC_BITS;
	localparam logic [DATA_WIDTH-2:0] RST_Y_STEP  = (DATA_WIDTH-1)'(1) << (FRAC_BITS - 8);
	localparam logic [ITER_BITS-1:0]  RST_MAX_ITER = ITER_BITS'(255);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_X_START,
		REG_X_STEP,
		REG_Y_TOP,
		REG_Y_STEP,
		REG_MAX_ITER
	} reg_idx_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] x_start;
		logic [DATA_WIDTH-2:0] x_step;
		logic [DATA_WIDTH-1:0] y_top;
		logic [DATA_WIDTH-2:0] y_step;
		logic [ITER_BITS-1:0]  max_iter;
	} cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COUNT_BITS-1:0] count;
		logic                  in_set;
		logic [DATA_WIDTH-1:0] fre;
		logic [DATA_WIDTH-1:0] fim;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CX,
		ST_CY,
		ST_CI,
		ST_RR,
		ST_II,
		ST_RI,
		ST_UPD
	} state_t;

	// Sign-extend a data word to product width
	function automatic logic [PROD_W-1:0] sext_dw(input logic [DATA_WIDTH-1:0] v);
		return {{(PROD_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
	endfunction

	// Clamp a product-width signed value to the signed data range
	function automatic logic [DATA_WIDTH-1:0] sat_dw(input logic [PROD_W-1:0] v);
		logic [DATA_WIDTH-1:0] r;
		if (!v[PROD_W-1] && (v[PROD_W-2:DATA_WIDTH-1] != '0)) begin
			r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else if (v[PROD_W-1] && (v[PROD_W-2:DATA_WIDTH-1] != '1)) begin
			r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			r = v[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/met_cfg_regs.sv
// Configuration register file of the Mandelbrot escape-time core.
`timescale 1ns / 1ps
module met_cfg_regs
	import met_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]   cfg_wdata,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_start  <= RST_X_START;
			cfg_q.x_step   <= RST_X_STEP;
			cfg_q.y_top    <= RST_Y_TOP;
			cfg_q.y_step   <= RST_Y_STEP;
			cfg_q.max_iter <= RST_MAX_ITER;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_START:  cfg_q.x_start  <= cfg_wdata;
				REG_X_STEP:   cfg_q.x_step   <= cfg_wdata[DATA_WIDTH-2:0];
				REG_Y_TOP:    cfg_q.y_top    <= cfg_wdata;
				REG_Y_STEP:   cfg_q.y_step   <= cfg_wdata[DATA_WIDTH-2:0];
				REG_MAX_ITER: cfg_q.max_iter <= cfg_wdata[ITER_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/met_mult.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module met_mult
	import met_pkg::*;
(
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] op_a,
	input  logic [DATA_WIDTH-1:0] op_b,
	output logic [PROD_W-1:0]     prod_q
);

	logic signed [DATA_WIDTH-1:0] sa;
	logic signed [DATA_WIDTH-1:0] sb;
	logic signed [PROD_W-1:0]     prod;

	assign sa   = $signed(op_a);
	assign sb   = $signed(op_b);
	assign prod = sa * sb;

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

endmodule

// File: rtl/core/met_engine.sv
// Sequencer and datapath of the escape-time iteration around the shared multiplier.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_core_macros.svh"
module met_engine
	import met_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  start,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	output logic                  busy,
	output logic                  done,
	output res_t                  res,
	output logic [DATA_WIDTH-1:0] mul_a,
	output logic [DATA_WIDTH-1:0] mul_b,
	input  logic [PROD_W-1:0]     prod
);

	state_t                state_q;
	state_t                state_d;
	logic                  done_q;
	res_t                  res_q;
	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic [DATA_WIDTH-1:0] cre_q;
	logic [DATA_WIDTH-1:0] cim_q;
	logic [DATA_WIDTH-1:0] zr_q;
	logic [DATA_WIDTH-1:0] zi_q;
	logic [PROD_W-1:0]     rr_q;
	logic [PROD_W-1:0]     ii_q;
	logic [ITER_BITS-1:0]  k_q;

	logic [PROD_W-1:0]     norm;
	logic                  escape;
	logic                  last;
	logic                  finish;
	logic [PROD_W-1:0]     diff;
	logic [PROD_W-1:0]     sum_r;
	logic [PROD_W-1:0]     sum_i;

	// squares are non-negative and at most 2^(PROD_W-2), so the sum cannot wrap
	assign norm   = PROD_W'(rr_q[PROD_W-2:0]) + PROD_W'(prod[PROD_W-2:0]);
	assign escape = (k_q != '0) && (norm > ESC_LIMIT);
	assign last   = (k_q == cfg.max_iter);
	assign finish = (state_q == ST_RI) && (escape || last);

	// round update: rr_q, ii_q hold the squares, prod holds zr*zi
	assign diff  = rr_q - ii_q;
	assign sum_r = $unsigned($signed(diff) >>> FRAC_BITS) + sext_dw(cre_q);
	assign sum_i = $unsigned($signed(prod) >>> (FRAC_BITS - 1)) + sext_dw(cim_q);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

	always_comb begin
		state_d = state_q;
		mul_a   = zr_q;
		mul_b   = zr_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CX;
				end
			end
			ST_CX: begin
				mul_a   = {{(DATA_WIDTH-COORD_BITS){1'b0}}, px_q};
				mul_b   = {1'b0, cfg.x_step};
				state_d = ST_CY;
			end
			ST_CY: begin
				mul_a   = {{(DATA_WIDTH-COORD_BITS){1'b0}}, py_q};
				mul_b   = {1'b0, cfg.y_step};
				state_d = ST_CI;
			end
			ST_CI: begin
				state_d = ST_RR;
			end
			ST_RR: begin
				state_d = ST_II;
			end
			ST_II: begin
				mul_a   = zi_q;
				mul_b   = zi_q;
				state_d = ST_RI;
			end
			ST_RI: begin
				mul_b   = zi_q;
				state_d = (escape || last) ? ST_IDLE : ST_UPD;
			end
			ST_UPD: begin
				state_d = ST_RR;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					px_q <= pixel_x;
					py_q <= pixel_y;
				end
			end
			ST_CY: begin
				cre_q <= sat_dw(sext_dw(cfg.x_start) + prod);
			end
			ST_CI: begin
				cim_q <= sat_dw(sext_dw(cfg.y_top) - prod);
				zr_q  <= '0;
				zi_q  <= '0;
				k_q   <= '0;
			end
			ST_II: begin
				rr_q <= prod;
			end
			ST_RI: begin
				ii_q <= prod;
			end
			ST_UPD: begin
				zr_q <= sat_dw(sum_r);
				zi_q <= sat_dw(sum_i);
				k_q  <= k_q + 1'b1;
			end
			default: ;
		endcase
		if (finish) begin
			res_q.x      <= px_q;
			res_q.y      <= py_q;
			res_q.in_set <= !escape;
			res_q.count  <= escape ? COUNT_BITS'(k_q - 1'b1)
			                       : COUNT_BITS'(cfg.max_iter) + 1'b1;
			res_q.fre    <= escape ? zr_q : cre_q;
			res_q.fim    <= escape ? zi_q : cim_q;
		end
	end

	`MET_ASSERT_NXT(a_done_single, done_q, !done_q)
	`MET_ASSERT_NXT(a_start_launch, start && (state_q == ST_IDLE), state_q == ST_CX)
	`MET_ASSERT_IMP(a_inside_count, done_q && res_q.in_set,
		res_q.count == COUNT_BITS'(cfg.max_iter) + 1'b1)
	`MET_ASSERT_IMP(a_escape_count, done_q && !res_q.in_set,
		res_q.count < COUNT_BITS'(cfg.max_iter))
	`MET_ASSERT_IMP(a_round_bound, (state_q == ST_RR) || (state_q == ST_UPD),
		k_q <= cfg.max_iter)

endmodule

// File: rtl/core/mandelbrot_escape_time_core.sv
// Top level of the Mandelbrot escape-time core: config registers, sequencer, shared multiplier.
// Each round uses the single multiplier for zr*zr, zi*zi and zr*zi, then an update state
//   forms the new iterate; a new pixel is accepted only while idle, and the done cycle is idle.
// Reset: arst_n clears the sequencer and the strobe, and loads the register defaults.
// Results are shown for one cycle with done; the receiver cannot stall them.
`timescale 1ns / 1ps
module mandelbrot_escape_time_core
	import met_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]   cfg_wdata,
	// pixel command
	input  logic                    start,
	output logic                    busy,
	input  logic [COORD_BITS-1:0]   pixel_x,
	input  logic [COORD_BITS-1:0]   pixel_y,
	// result strobe and fields
	output logic                    done,
	output logic [COORD_BITS-1:0]   out_x,
	output logic [COORD_BITS-1:0]   out_y,
	output logic [COUNT_BITS-1:0]   escape_count,
	output logic                    inside_res,
	output logic [DATA_WIDTH-1:0]   final_re,
	output logic [DATA_WIDTH-1:0]   final_im
);

	cfg_t                  cfg;
	res_t                  res;
	logic [DATA_WIDTH-1:0] mul_a;
	logic [DATA_WIDTH-1:0] mul_b;
	logic [PROD_W-1:0]     prod_q;

	// Register file: a write transaction lands whenever cfg_valid is high.
	// Writes are only expected while busy is low and no result is pending.
	met_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Sequencer: forms c from the pixel index with two multiplies, then runs
	// the rounds. The norm of each new iterate comes for free from the
	// squares of the following round, so one extra square pass ends the search.
	met_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.start   (start),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.busy    (busy),
		.done    (done),
		.res     (res),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.prod    (prod_q)
	);

	// One 32x32 signed multiplier, product registered before use.
	met_mult u_mult (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// Unpack the result register onto the result ports; it holds until the next pixel ends.
	assign out_x        = res.x;
	assign out_y        = res.y;
	assign escape_count = res.count;
	assign inside_res   = res.in_set;
	assign final_re     = res.fre;
	assign final_im     = res.fim;

endmodule
